FILE: rtl/core/psx_pkg.sv
// ----------------------------------------------------------------------------
// psx_pkg
// Shared constants and types of the printable string extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package psx_pkg;

   // Longest minimum run length that the block supports.
   localparam int MAX_MIN_LENGTH = 16;
   // Width of the internal byte position counter.
   localparam int OFFSET_WIDTH   = 32;

   localparam int PEND_DEPTH = MAX_MIN_LENGTH - 1;
   localparam int PEND_AW    = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
   localparam int PEND_CW    = $clog2(PEND_DEPTH + 1);
   localparam int CNT_W      = $clog2(MAX_MIN_LENGTH + 1);

   localparam int BYTE_W     = 8;
   localparam int CFG_W      = 5;
   localparam int OUT_OFF_W  = 32;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;

   localparam logic [BYTE_W-1:0] PRINT_LO    = 8'h20;
   localparam logic [BYTE_W-1:0] PRINT_HI    = 8'h7e;
   localparam logic [CFG_W-1:0]  DEFAULT_MIN = 5'd4;

   // What the datapath places in the result register.
   typedef enum logic [1:0] {
      K_FLUSH = 2'd0,
      K_BYTE  = 2'd1,
      K_END   = 2'd2
   } emit_kind_type;

   typedef struct packed {
      logic          accept;
      logic          emit;
      emit_kind_type kind;
      logic          k_clear;
      logic          k_inc;
   } psx_cmd_type;

   typedef struct packed {
      logic in_printable;
      logic reported;
      logic reach;
      logic cnt_zero;
      logic flush_last;
      logic eod;
      logic out_free;
   } psx_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/psx_ctrl.sv
// ----------------------------------------------------------------------------
// psx_ctrl
// Sequencer that accepts one byte and then steps through its results.
// ----------------------------------------------------------------------------
`default_nettype none

module psx_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  psx_pkg::psx_status_type stat,
   output psx_pkg::psx_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_FLUSH = 4'b0010,
      S_BYTE  = 4'b0100,
      S_END   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;
   logic      emit;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign emit       = (state_ff != S_IDLE) && stat.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (stat.in_printable) begin
                  if (stat.reported) begin
                     state_in = S_BYTE;
                  end else if (stat.reach) begin
                     state_in = stat.cnt_zero ? S_BYTE : S_FLUSH;
                  end
               end else if (stat.reported) begin
                  state_in = S_END;
               end
            end
         end
         S_FLUSH: begin
            if (emit && stat.flush_last) begin
               state_in = S_BYTE;
            end
         end
         S_BYTE: begin
            if (emit) begin
               state_in = stat.eod ? S_END : S_IDLE;
            end
         end
         S_END: begin
            if (emit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.accept  = accept;
      cmd.emit    = emit;
      cmd.k_clear = accept;
      cmd.k_inc   = emit && (state_ff == S_FLUSH);
      case (state_ff)
         S_FLUSH: cmd.kind = psx_pkg::K_FLUSH;
         S_BYTE:  cmd.kind = psx_pkg::K_BYTE;
         default: cmd.kind = psx_pkg::K_END;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/psx_dp.sv
// ----------------------------------------------------------------------------
// psx_dp
// Run tracking, pending byte store, offsets and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module psx_dp (
   input  wire                                     clock,
   input  wire                                     reset,
   input  psx_pkg::psx_cmd_type                    cmd,
   output psx_pkg::psx_status_type                 stat,
   input  wire [psx_pkg::BYTE_W-1:0]               in_byte,
   input  wire                                     in_eod,
   input  wire                                     csr_valid,
   input  wire [psx_pkg::CFG_W-1:0]                csr_data,
   input  wire                                     rsp_tready,
   output logic                                    rsp_tvalid,
   output logic [psx_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic [psx_pkg::RSP_USER_W-1:0]          rsp_tuser,
   output logic                                    rsp_tlast
);

   logic [psx_pkg::CFG_W-1:0]        min_len_ff;
   logic [psx_pkg::CNT_W-1:0]        m_eff;
   logic [psx_pkg::CNT_W-1:0]        run_ff, run_in;
   logic                             reported_ff, reported_in;
   logic [psx_pkg::OFFSET_WIDTH-1:0] pos_ff, pos_in;
   logic [psx_pkg::BYTE_W-1:0]       pend_ff [psx_pkg::PEND_DEPTH];

   logic                             in_printable;
   logic                             reach;
   logic [psx_pkg::PEND_CW-1:0]      cnt_sat;
   logic                             store_en;

   logic [psx_pkg::BYTE_W-1:0]       byte_ff;
   logic                             eod_ff;
   logic [psx_pkg::OFFSET_WIDTH-1:0] cur_pos_ff;
   logic [psx_pkg::PEND_CW-1:0]      cnt_ff;
   logic                             first_byte_ff;
   logic [psx_pkg::PEND_AW-1:0]      k_ff;

   logic                             out_valid_ff;
   logic [psx_pkg::BYTE_W-1:0]       out_byte_ff, out_byte_in;
   logic [psx_pkg::OFFSET_WIDTH-1:0] out_off_ff, out_off_in;
   logic                             out_first_ff, out_first_in;
   logic                             out_end_ff, out_end_in;
   logic                             out_last_ff, out_last_in;
   logic [psx_pkg::PEND_CW-1:0]      back_dist;

   // Out-of-range minimum values are clamped into 1..MAX_MIN_LENGTH.
   always_comb begin
      if (min_len_ff == '0) begin
         m_eff = psx_pkg::CNT_W'(1);
      end else if (int'(min_len_ff) > psx_pkg::MAX_MIN_LENGTH) begin
         m_eff = psx_pkg::CNT_W'(psx_pkg::MAX_MIN_LENGTH);
      end else begin
         m_eff = psx_pkg::CNT_W'(min_len_ff);
      end
   end

   assign in_printable = (in_byte >= psx_pkg::PRINT_LO) && (in_byte <= psx_pkg::PRINT_HI);
   assign reach        = ({1'b0, run_ff} + 1'b1) >= {1'b0, m_eff};
   assign cnt_sat      = (int'(run_ff) > psx_pkg::PEND_DEPTH) ?
                         psx_pkg::PEND_CW'(psx_pkg::PEND_DEPTH) : psx_pkg::PEND_CW'(run_ff);
   assign store_en     = cmd.accept && in_printable && !reported_ff && !reach
                         && (int'(run_ff) < psx_pkg::PEND_DEPTH);

   always_comb begin
      run_in      = run_ff;
      reported_in = reported_ff;
      if (in_printable) begin
         if (int'(run_ff) < psx_pkg::MAX_MIN_LENGTH) begin
            run_in = run_ff + 1'b1;
         end
         reported_in = reported_ff || reach;
      end else begin
         run_in      = '0;
         reported_in = 1'b0;
      end
      pos_in = pos_ff + 1'b1;
      if (in_eod) begin
         run_in      = '0;
         reported_in = 1'b0;
         pos_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff  <= psx_pkg::DEFAULT_MIN;
         run_ff      <= '0;
         reported_ff <= 1'b0;
         pos_ff      <= '0;
      end else begin
         if (csr_valid) begin
            min_len_ff <= csr_data;
         end
         if (cmd.accept) begin
            run_ff      <= run_in;
            reported_ff <= reported_in;
            pos_ff      <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         pend_ff[run_ff[psx_pkg::PEND_AW-1:0]] <= in_byte;
      end
      if (cmd.accept) begin
         byte_ff       <= in_byte;
         eod_ff        <= in_eod;
         cur_pos_ff    <= pos_ff;
         cnt_ff        <= cnt_sat;
         first_byte_ff <= !reported_ff && (cnt_sat == '0);
      end
      if (cmd.k_clear) begin
         k_ff <= '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   // A flushed byte sits cnt - k places before the byte that completed the run.
   assign back_dist = cnt_ff - psx_pkg::PEND_CW'(k_ff);

   always_comb begin
      out_byte_in  = '0;
      out_off_in   = cur_pos_ff;
      out_first_in = 1'b0;
      out_end_in   = 1'b0;
      out_last_in  = 1'b1;
      case (cmd.kind)
         psx_pkg::K_FLUSH: begin
            out_byte_in  = pend_ff[k_ff];
            out_off_in   = cur_pos_ff - psx_pkg::OFFSET_WIDTH'(back_dist);
            out_first_in = (k_ff == '0);
            out_last_in  = 1'b0;
         end
         psx_pkg::K_BYTE: begin
            out_byte_in  = byte_ff;
            out_first_in = first_byte_ff;
            out_last_in  = !eod_ff;
         end
         psx_pkg::K_END: begin
            out_end_in = 1'b1;
         end
         default: begin
            out_end_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_byte_ff  <= out_byte_in;
         out_off_ff   <= out_off_in;
         out_first_ff <= out_first_in;
         out_end_ff   <= out_end_in;
         out_last_ff  <= out_last_in;
      end
   end

   always_comb begin
      stat.in_printable = in_printable;
      stat.reported     = reported_ff;
      stat.reach        = reach;
      stat.cnt_zero     = (cnt_sat == '0);
      stat.flush_last   = ((psx_pkg::PEND_CW'(k_ff) + 1'b1) == cnt_ff);
      stat.eod          = eod_ff;
      stat.out_free     = !out_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {psx_pkg::OUT_OFF_W'(out_off_ff), out_byte_ff};
   assign rsp_tuser  = {out_end_ff, out_first_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/printable_string_extractor_core.sv
// ----------------------------------------------------------------------------
// printable_string_extractor_core
// Reports runs of printable bytes that reach a programmable minimum length.
// ----------------------------------------------------------------------------
// The block takes one byte per beat and accepts it in the idle state; a byte
// that yields no result lets the next byte in on the following cycle, while a
// byte that completes a run has its pending bytes flushed by the sequencer,
// which walks the pending store one entry per cycle while the output register
// is free. Results leave through a single output register, so a new byte is
// taken while the last result still waits.
`default_nettype none

module printable_string_extractor_core (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire [7:0]                            req_tdata,  // [7:0] data_byte
   input  wire                                  req_tlast,  // end_of_data
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [psx_pkg::CFG_W-1:0]             csr_data,   // minimum_length
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // [7:0] out_byte, [39:8] byte_offset
   output logic [psx_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // [0] first_of_string, [1] end_marker
   output logic [psx_pkg::RSP_USER_W-1:0]       rsp_tuser,
   output logic                                 rsp_tlast   // last
);

   psx_pkg::psx_cmd_type    cmd;
   psx_pkg::psx_status_type stat;

   assign csr_ready = 1'b1;

   psx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   psx_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_byte    (req_tdata),
      .in_eod     (req_tlast),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: rtl/core/psx_checker.sv
// ----------------------------------------------------------------------------
// psx_checker
// Port-level checks of the printable string extractor.
// ----------------------------------------------------------------------------
`default_nettype none

module psx_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [psx_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire [psx_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input wire                              rsp_tlast
);

   // A stalled result beat keeps its contents.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // An end marker carries no byte and always ends the results of its input.
   a_end_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> (rsp_tdata[7:0] == 8'h00) && rsp_tlast)
      else $error("malformed end marker");

   // A string cannot open and close on the same beat.
   a_first_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("first and end flags together");

   // Every reported string byte is printable.
   a_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |->
         (rsp_tdata[7:0] >= psx_pkg::PRINT_LO) && (rsp_tdata[7:0] <= psx_pkg::PRINT_HI))
      else $error("non-printable byte reported");

endmodule

bind printable_string_extractor_core psx_checker u_psx_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
